// ----- hdl/tmc_pkg.sv -----
package tmc_pkg;

	// Field types at the widths of the ports.
	typedef logic signed [15:0] quat_t;
	typedef logic signed [15:0] scale_t;
	typedef logic signed [31:0] fix_t;

	// Internal arithmetic types.
	// A Q1.15 by Q1.15 product.
	typedef logic signed [31:0] qprod_t;
	// A rotation term in Q4.30, with room for sums of doubled products.
	typedef logic signed [33:0] term_t;
	// A term times a Q8.8 scale.
	typedef logic signed [49:0] mprod_t;
	// A rounding sum, wide enough to hold every bit of the shifted result.
	typedef logic signed [53:0] rsum_t;
	typedef logic [1:0] row_t;

	localparam row_t ROW_0 = 2'd0;
	localparam row_t ROW_1 = 2'd1;
	localparam row_t ROW_2 = 2'd2;
	localparam row_t ROW_LAST = 2'd3;

	localparam term_t TERM_ONE = 34'sh0_4000_0000;
	localparam fix_t FIX_ONE = 32'sh0001_0000;
	localparam fix_t FIX_ZERO = 32'sh0000_0000;
	localparam rsum_t ROUND_BIAS = 54'sd2097152;
	localparam int RoundShift = 22;

	// One classified item: the nine rotation terms in row-major order,
	// the axis scales and the translation.
	typedef struct packed {
		term_t [8:0] m;
		scale_t [2:0] s;
		fix_t [2:0] t;
	} item_t;

	// One matrix row as it leaves the block.
	typedef struct packed {
		row_t row;
		fix_t [3:0] col;
		logic last;
	} row_res_t;

endpackage

// ----- hdl/tmc_fifo.sv -----
module tmc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [WIDTH-1:0] wdata,
	input logic pop,
	output logic empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push;
	logic do_pop;

	// Full and empty come from the count alone, so neither side sees the other combinationally.
	assign full = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("fifo count exceeds depth");

endmodule

// ----- hdl/tmc_front.sv -----
module tmc_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input tmc_pkg::quat_t quat_x,
	input tmc_pkg::quat_t quat_y,
	input tmc_pkg::quat_t quat_z,
	input tmc_pkg::quat_t quat_w,
	input tmc_pkg::scale_t scale_x,
	input tmc_pkg::scale_t scale_y,
	input tmc_pkg::scale_t scale_z,
	input tmc_pkg::fix_t trans_x,
	input tmc_pkg::fix_t trans_y,
	input tmc_pkg::fix_t trans_z,
	output logic q_push,
	input logic q_full,
	output tmc_pkg::item_t q_item
);
	import tmc_pkg::*;

	logic valid_s1;
	logic valid_s2;
	logic ready_s1;
	logic ready_s2;
	logic accept;

	quat_t qx_s1;
	quat_t qy_s1;
	quat_t qz_s1;
	quat_t qw_s1;
	scale_t [2:0] scale_s1;
	fix_t [2:0] trans_s1;

	qprod_t xx_s2;
	qprod_t yy_s2;
	qprod_t zz_s2;
	qprod_t xy_s2;
	qprod_t yz_s2;
	qprod_t xz_s2;
	qprod_t xw_s2;
	qprod_t yw_s2;
	qprod_t zw_s2;
	scale_t [2:0] scale_s2;
	fix_t [2:0] trans_s2;

	term_t dxx;
	term_t dyy;
	term_t dzz;
	term_t dxy;
	term_t dyz;
	term_t dxz;
	term_t dxw;
	term_t dyw;
	term_t dzw;

	// A stage moves on when it is empty or its successor takes its contents.
	assign ready_s2 = !valid_s2 || !q_full;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign full = !ready_s1;
	assign accept = push && ready_s1;
	assign q_push = valid_s2 && !q_full;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= accept;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			qx_s1 <= quat_x;
			qy_s1 <= quat_y;
			qz_s1 <= quat_z;
			qw_s1 <= quat_w;
			scale_s1 <= {scale_z, scale_y, scale_x};
			trans_s1 <= {trans_z, trans_y, trans_x};
		end
	end

	// The nine quaternion products, one multiplier each.
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			xx_s2 <= qx_s1 * qx_s1;
			yy_s2 <= qy_s1 * qy_s1;
			zz_s2 <= qz_s1 * qz_s1;
			xy_s2 <= qx_s1 * qy_s1;
			yz_s2 <= qy_s1 * qz_s1;
			xz_s2 <= qx_s1 * qz_s1;
			xw_s2 <= qw_s1 * qx_s1;
			yw_s2 <= qw_s1 * qy_s1;
			zw_s2 <= qw_s1 * qz_s1;
			scale_s2 <= scale_s1;
			trans_s2 <= trans_s1;
		end
	end

	// Doubled products in Q4.30.
	assign dxx = term_t'(xx_s2) <<< 1;
	assign dyy = term_t'(yy_s2) <<< 1;
	assign dzz = term_t'(zz_s2) <<< 1;
	assign dxy = term_t'(xy_s2) <<< 1;
	assign dyz = term_t'(yz_s2) <<< 1;
	assign dxz = term_t'(xz_s2) <<< 1;
	assign dxw = term_t'(xw_s2) <<< 1;
	assign dyw = term_t'(yw_s2) <<< 1;
	assign dzw = term_t'(zw_s2) <<< 1;

	// Rotation matrix terms, row-major.
	always_comb begin
		q_item.m[0] = TERM_ONE - (dyy + dzz);
		q_item.m[1] = dxy - dzw;
		q_item.m[2] = dxz + dyw;
		q_item.m[3] = dxy + dzw;
		q_item.m[4] = TERM_ONE - (dxx + dzz);
		q_item.m[5] = dyz - dxw;
		q_item.m[6] = dxz - dyw;
		q_item.m[7] = dyz + dxw;
		q_item.m[8] = TERM_ONE - (dxx + dyy);
		q_item.s = scale_s2;
		q_item.t = trans_s2;
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && q_full |=> valid_s2)
		else $error("front stage lost an item while the queue was full");

endmodule

// ----- hdl/tmc_back.sv -----
module tmc_back (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	output logic q_pop,
	input tmc_pkg::item_t q_item,
	output logic res_push,
	input logic res_full,
	output tmc_pkg::row_res_t res
);
	import tmc_pkg::*;

	row_t row_q;
	logic ready;
	logic take;
	term_t [2:0] sel_m;
	fix_t sel_t;

	logic valid_s1;
	row_t row_s1;
	mprod_t [2:0] prod_s1;
	fix_t trans_s1;

	rsum_t [2:0] rsum;

	assign ready = !valid_s1 || !res_full;
	assign take = !q_empty && ready;
	assign q_pop = take && (row_q == ROW_LAST);
	assign res_push = valid_s1 && !res_full;

	// Pick the terms and the translation of the current row.
	always_comb begin
		unique case (row_q)
			ROW_0: begin
				sel_m = {q_item.m[2], q_item.m[1], q_item.m[0]};
				sel_t = q_item.t[0];
			end
			ROW_1: begin
				sel_m = {q_item.m[5], q_item.m[4], q_item.m[3]};
				sel_t = q_item.t[1];
			end
			ROW_2: begin
				sel_m = {q_item.m[8], q_item.m[7], q_item.m[6]};
				sel_t = q_item.t[2];
			end
			default: begin
				sel_m = '0;
				sel_t = FIX_ONE;
			end
		endcase
	end

	// Row sequencer and stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= ROW_0;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				row_q <= row_q + 1'b1;
			end
			if (ready) begin
				valid_s1 <= take;
			end
		end
	end

	// Scale each column term by its axis scale.
	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= mprod_t'(sel_m[i]) * mprod_t'(q_item.s[i]);
			end
			row_s1 <= row_q;
			trans_s1 <= sel_t;
		end
	end

	// Round half up to Q16.16 and form the result row.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rsum[i] = rsum_t'(prod_s1[i]) + ROUND_BIAS;
			res.col[i] = rsum[i][RoundShift +: 32];
		end
		res.col[3] = trans_s1;
		res.row = row_s1;
		res.last = (row_s1 == ROW_LAST);
	end

	a_row_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		take && row_q == ROW_LAST |=> row_q == ROW_0)
		else $error("row counter did not wrap after the last row");

	a_row_steps: assert property (@(posedge clk) disable iff (!arst_n)
		take && row_q != ROW_LAST |=> row_q == $past(row_q) + 2'd1)
		else $error("row counter skipped a row");

	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && row_s1 == ROW_LAST |-> res.col[0] == FIX_ZERO && res.col[3] == FIX_ONE)
		else $error("constant row is not 0, 0, 0, 1");

endmodule

// ----- hdl/trs_matrix_compose.sv -----
// Builds a 4x4 affine transform from a Q1.15 rotation quaternion, a Q8.8
// per-axis scale and a Q16.16 translation, and delivers it as four row
// transactions (rows 0 to 3 in order, last_row set on row 3). Each rotation
// entry is scaled by its column's axis scale and rounded half up to Q16.16;
// the quaternion is used as given, without normalization. The back end
// produces one row per cycle while the item queue holds an item and the
// result queue has room, with three term-by-scale multipliers, and that row
// sequencer sets the item rate. The front end forms the quaternion terms
// in two stages and hands them to the back end through a short queue, so a
// new item is taken while earlier rows are still being worked out or wait to
// be popped.
module trs_matrix_compose #(
	parameter int QUEUE_DEPTH = 2,
	parameter int RESULT_DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic signed [15:0] quat_x,
	input logic signed [15:0] quat_y,
	input logic signed [15:0] quat_z,
	input logic signed [15:0] quat_w,
	input logic signed [15:0] scale_x,
	input logic signed [15:0] scale_y,
	input logic signed [15:0] scale_z,
	input logic signed [31:0] trans_x,
	input logic signed [31:0] trans_y,
	input logic signed [31:0] trans_z,
	input logic pop,
	output logic empty,
	output logic [1:0] row_index,
	output logic signed [31:0] col0,
	output logic signed [31:0] col1,
	output logic signed [31:0] col2,
	output logic signed [31:0] col3,
	output logic last_row
);
	import tmc_pkg::*;

	localparam int ItemW = $bits(item_t);
	localparam int ResW = $bits(row_res_t);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	item_t q_wr_item;
	logic [ItemW-1:0] q_rd_vec;
	item_t q_rd_item;

	logic res_push;
	logic res_full;
	row_res_t res_wr;
	logic [ResW-1:0] res_rd_vec;
	row_res_t res_rd;

	// Front end: capture and quaternion terms.
	tmc_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.push (push),
		.full (full),
		.quat_x (quat_x),
		.quat_y (quat_y),
		.quat_z (quat_z),
		.quat_w (quat_w),
		.scale_x (scale_x),
		.scale_y (scale_y),
		.scale_z (scale_z),
		.trans_x (trans_x),
		.trans_y (trans_y),
		.trans_z (trans_z),
		.q_push (q_push),
		.q_full (q_full),
		.q_item (q_wr_item)
	);

	// Queue between the front and back ends.
	tmc_fifo #(
		.WIDTH (ItemW),
		.DEPTH (QUEUE_DEPTH)
	) u_item_q (
		.clk (clk),
		.arst_n (arst_n),
		.push (q_push),
		.full (q_full),
		.wdata (q_wr_item),
		.pop (q_pop),
		.empty (q_empty),
		.rdata (q_rd_vec)
	);

	assign q_rd_item = item_t'(q_rd_vec);

	// Back end: one row per cycle while the result queue has room.
	tmc_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.q_empty (q_empty),
		.q_pop (q_pop),
		.q_item (q_rd_item),
		.res_push (res_push),
		.res_full (res_full),
		.res (res_wr)
	);

	// Result queue that faces the consumer.
	tmc_fifo #(
		.WIDTH (ResW),
		.DEPTH (RESULT_DEPTH)
	) u_res_q (
		.clk (clk),
		.arst_n (arst_n),
		.push (res_push),
		.full (res_full),
		.wdata (res_wr),
		.pop (pop),
		.empty (empty),
		.rdata (res_rd_vec)
	);

	// Unpack the oldest row onto the result ports.
	assign res_rd = row_res_t'(res_rd_vec);
	assign row_index = res_rd.row;
	assign col0 = res_rd.col[0];
	assign col1 = res_rd.col[1];
	assign col2 = res_rd.col[2];
	assign col3 = res_rd.col[3];
	assign last_row = res_rd.last;

endmodule
